// ===== rtl/core/move_to_front_depth_core_defines.svh =====
// Assertion macros shared by the move-to-front depth core.
`ifndef MOVE_TO_FRONT_DEPTH_CORE_DEFINES_SVH
`define MOVE_TO_FRONT_DEPTH_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MTFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mtfd_pkg.sv =====
// Package with types and constants for the move-to-front depth core.
package mtfd_pkg;

    // Field widths of the item channels and the count register.
    localparam int ITEM_ID_W     = 11;
    localparam int COUNT_W       = 11;
    localparam int ABOVE_W       = 10;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    // Largest reported depth; deeper matches saturate here.
    localparam logic [ABOVE_W-1:0] ABOVE_MAX = '1;

    // Default stack size and reset value of the item count register.
    localparam int                 MTFD_MAX_ITEMS = 1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET    = 11'd1024;

    // Register index decoded from the word address.
    localparam logic REG_ITEM_COUNT = 1'b0;

    // Input item.
    typedef struct packed {
        logic                 restart;
        logic [ITEM_ID_W-1:0] item_id;
    } mtfd_in_t;

    // Result item.
    typedef struct packed {
        logic [ABOVE_W-1:0] items_above;
        logic               bad_item;
    } mtfd_out_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic restore;
        logic compare;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/mtfd_cell.sv =====
// One stack cell: holds the item at a fixed depth, compares and shifts.
module mtfd_cell #(
    parameter int ENTRY_W = 11,
    parameter int DEPTH_W = 10,
    parameter int INDEX   = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtfd_pkg::cell_ctrl_t ctrl,
    input  logic [ENTRY_W-1:0]   key,
    input  logic [ENTRY_W-1:0]   upper,
    input  logic [DEPTH_W-1:0]   depth,
    output logic [ENTRY_W-1:0]   value,
    output logic                 match
);
    import mtfd_pkg::*;

    // Item held here in the initial order, and this cell's depth.
    localparam logic [ENTRY_W-1:0] INIT_VALUE  = ENTRY_W'(INDEX + 1);
    localparam logic [DEPTH_W-1:0] INDEX_DEPTH = DEPTH_W'(INDEX);

    logic [ENTRY_W-1:0] value_reg;
    logic [ENTRY_W-1:0] value_next;
    logic               match_reg;
    logic               match_next;

    // A restart reloads the initial order; a move pulls the item from the
    // cell above when this cell lies at or above the matched depth.
    always_comb
    begin
        value_next = value_reg;
        priority if (ctrl.restore)
        begin
            value_next = INIT_VALUE;
        end
        else if (ctrl.shift && (INDEX_DEPTH <= depth))
        begin
            value_next = upper;
        end
        match_next = ctrl.compare ? (value_reg == key) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= INIT_VALUE;
            match_reg <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            match_reg <= match_next;
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== rtl/core/mtfd_enc.sv =====
// Encoder that turns the row of cell match flags into a registered depth.
module mtfd_enc #(
    parameter int MAX_ITEMS = 1024,
    parameter int DEPTH_W   = 10
) (
    input  logic                 clk,
    input  logic                 load,
    input  logic [MAX_ITEMS-1:0] match,
    output logic [DEPTH_W-1:0]   depth
);
    import mtfd_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;

    // At most one cell matches, so each depth bit is the OR of the
    // match flags of the cells whose index has that bit set.
    always_comb
    begin
        depth_next = '0;
        for (int b = 0; b < DEPTH_W; b++)
        begin
            for (int d = 0; d < MAX_ITEMS; d++)
            begin
                if (((d >> b) & 1) == 1)
                begin
                    depth_next[b] = depth_next[b] | match[d];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            depth_reg <= depth_next;
        end
    end

    assign depth = depth_reg;

endmodule

// ===== rtl/core/move_to_front_depth_core.sv =====
// Top level of the move-to-front depth core: sequencer, cell row, APB register.
//
//   channel   direction  handshake                      payload
//   in        sink       in_valid / in_ready            in_data  (mtfd_in_t)
//   out       source     out_valid / out_ready          out_data (mtfd_out_t)
//   apb       slave      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each item steps through the states: compare in every cell, encode the match depth,
// then move the cells above down by one while the result is registered.
// The next item is accepted at the edge of the move, so a new item can enter as
// the last result is written while out_ready stays high; a held result stalls the move.
// Reset loads the initial order into the cells at once, no clearing pass.
`include "move_to_front_depth_core_defines.svh"

module move_to_front_depth_core #(
    parameter int MAX_ITEMS = mtfd_pkg::MTFD_MAX_ITEMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mtfd_pkg::mtfd_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mtfd_pkg::mtfd_out_t                 out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mtfd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mtfd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mtfd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mtfd_pkg::*;

    localparam int ENTRY_W = $clog2(MAX_ITEMS + 1);
    localparam int DEPTH_W = $clog2(MAX_ITEMS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_ENC  = 4'b0100,
        ST_MOVE = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] item_count_reg;
    logic [COUNT_W-1:0] item_count_next;
    logic [ENTRY_W-1:0] key_reg;
    logic [ENTRY_W-1:0] key_next;
    logic               bad_reg;
    logic               bad_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    mtfd_out_t          out_data_reg;
    mtfd_out_t          out_data_next;

    logic               accept;
    logic               slot_free;
    logic               moving;
    logic               cfg_write;
    cell_ctrl_t         cell_ctrl;
    logic [DEPTH_W-1:0] depth;
    logic [MAX_ITEMS-1:0] match_bits;
    logic [ENTRY_W-1:0] cell_value [MAX_ITEMS];

    // Handshake: a new item enters when idle or on the edge that finishes a move.
    assign slot_free = !out_valid_reg || out_ready;
    assign moving    = (state_reg == ST_MOVE) && slot_free;
    assign in_ready  = (state_reg == ST_IDLE) || moving;
    assign accept    = in_valid && in_ready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (moving)
                begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Capture the key and range check of an accepted item.
    always_comb
    begin
        key_next = key_reg;
        bad_next = bad_reg;
        if (accept)
        begin
            key_next = ENTRY_W'(in_data.item_id);
            bad_next = (in_data.item_id == '0) || (in_data.item_id > item_count_reg)
                || (32'(in_data.item_id) > 32'(MAX_ITEMS));
        end
    end

    // Broadcast controls; a restart on the same edge overrides the move.
    always_comb
    begin
        cell_ctrl.restore = accept && in_data.restart;
        cell_ctrl.compare = (state_reg == ST_CMP);
        cell_ctrl.shift   = moving && !bad_reg;
    end

    // Row of cells, each fed by its upper neighbor; the top cell takes the key.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic [ENTRY_W-1:0] upper;
        if (i == 0)
        begin : g_top
            assign upper = key_reg;
        end
        else
        begin : g_inner
            assign upper = cell_value[i-1];
        end
        mtfd_cell #(
            .ENTRY_W (ENTRY_W),
            .DEPTH_W (DEPTH_W),
            .INDEX   (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .key   (key_reg),
            .upper (upper),
            .depth (depth),
            .value (cell_value[i]),
            .match (match_bits[i])
        );
    end

    // Depth of the matching cell.
    mtfd_enc #(
        .MAX_ITEMS (MAX_ITEMS),
        .DEPTH_W   (DEPTH_W)
    ) u_enc (
        .clk   (clk),
        .load  (state_reg == ST_ENC),
        .match (match_bits),
        .depth (depth)
    );

    // Result register; a bad item reports a zero count.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (moving)
        begin
            out_valid_next         = 1'b1;
            out_data_next.bad_item = bad_reg;
            if (bad_reg)
            begin
                out_data_next.items_above = '0;
            end
            else if (32'(depth) > 32'(ABOVE_MAX))
            begin
                out_data_next.items_above = ABOVE_MAX;
            end
            else
            begin
                out_data_next.items_above = ABOVE_W'(depth);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Item count register on the APB port.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        item_count_next = item_count_reg;
        if (cfg_write && (paddr[2] == REG_ITEM_COUNT))
        begin
            item_count_next = pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ITEM_COUNT) ? APB_DATA_W'(item_count_reg) : '0;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            item_count_reg <= COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            item_count_reg <= item_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        bad_reg      <= bad_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The stack holds every item once, so an in-range item matches one cell.
    `MTFD_ASSERT_NOW(a_single_match, (state_reg == ST_ENC), $onehot0(match_bits), "two cells match")
    `MTFD_ASSERT_NOW(a_item_found, (state_reg == ST_ENC) && !bad_reg, $onehot(match_bits), "item not in stack")
    `MTFD_ASSERT_NEXT(a_accept_compares, accept, (state_reg == ST_CMP), "accepted item not compared")
    `MTFD_ASSERT_NEXT(a_move_delivers, moving, out_valid, "move without result")

endmodule

// ===== tb/move_to_front_depth_core_tb.sv =====
// Self-checking testbench for the move-to-front depth core with directed and random items.
module move_to_front_depth_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtfd_pkg::*;

    localparam int STACK_DEPTH  = MTFD_MAX_ITEMS;
    localparam int REG_SPARE    = 1;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS  = 56;
    localparam int MAX_REPORTS  = 10;

    localparam logic [APB_ADDR_W-1:0] ADDR_ITEM_COUNT = APB_ADDR_W'(4 * int'(REG_ITEM_COUNT));
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE      = APB_ADDR_W'(4 * REG_SPARE);

    // Tracks the item stack and the depths that the core should report.
    class mtf_scoreboard;
        logic [ITEM_ID_W-1:0] stack_order [STACK_DEPTH];
        logic [COUNT_W-1:0]   item_count;
        mtfd_out_t            depth_q [$];
        int unsigned          mismatches;

        function new();
            item_count = COUNT_RESET;
            mismatches = 0;
            restore_order();
        endfunction

        // Item k sits at depth k-1.
        function void restore_order();
            for (int d = 0; d < STACK_DEPTH; d++)
                stack_order[d] = ITEM_ID_W'(d + 1);
        endfunction

        function void set_count(input logic [APB_DATA_W-1:0] value);
            item_count = value[COUNT_W-1:0];
        endfunction

        function int pending();
            return depth_q.size();
        endfunction

        // Counts a failure and prints only the first few.
        function void flag(input string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // Works out the depth of an accepted item and moves it to the top.
        function void note_item(input mtfd_in_t it);
            mtfd_out_t res;
            int        depth;
            if (it.restart)
                restore_order();
            res = '0;
            if (it.item_id == '0 || it.item_id > item_count || int'(it.item_id) > STACK_DEPTH)
            begin
                res.bad_item = 1'b1;
            end
            else
            begin
                depth = 0;
                while (depth < STACK_DEPTH && stack_order[depth] != it.item_id)
                    depth++;
                if (depth < STACK_DEPTH)
                begin
                    for (int d = depth; d > 0; d--)
                        stack_order[d] = stack_order[d - 1];
                    stack_order[0] = it.item_id;
                end
                else
                begin
                    depth = 0;
                end
                res.items_above = (depth > int'(ABOVE_MAX)) ? ABOVE_MAX : ABOVE_W'(depth);
            end
            depth_q.push_back(res);
        endfunction

        // Compares one result with the oldest expected depth.
        function void check_result(input mtfd_out_t got);
            mtfd_out_t want;
            if (depth_q.size() == 0)
            begin
                flag($sformatf("unexpected result: items_above=%0d bad_item=%0b",
                               got.items_above, got.bad_item));
            end
            else
            begin
                want = depth_q.pop_front();
                if (got.items_above !== want.items_above)
                    flag($sformatf("items_above mismatch: expected %0d, got %0d",
                                   want.items_above, got.items_above));
                if (got.bad_item !== want.bad_item)
                    flag($sformatf("bad_item mismatch: expected %0b, got %0b",
                                   want.bad_item, got.bad_item));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    mtfd_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    mtfd_out_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mtf_scoreboard board;
    int            in_gap_max;
    int            out_stall_max;
    bit            hold_request;

    move_to_front_depth_core i_dut (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Every accepted item is noted and every accepted result is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(out_data);
            if (in_valid && in_ready)
                board.note_item(in_data);
        end
    end

    function automatic mtfd_in_t lookup(input logic rs, input int id);
        mtfd_in_t it;
        it.restart = rs;
        it.item_id = ITEM_ID_W'(id);
        return it;
    endfunction

    // Mostly valid ids, with a hot set near the top, plus bad ids and raw noise.
    function automatic mtfd_in_t random_item();
        mtfd_in_t it;
        int       lim;
        int       pick;
        lim  = (int'(board.item_count) > STACK_DEPTH) ? STACK_DEPTH : int'(board.item_count);
        pick = $urandom_range(0, 99);
        it.restart = ($urandom_range(0, 39) == 0);
        if (lim > 0 && pick < 45)
            it.item_id = ITEM_ID_W'($urandom_range(1, (lim < 8) ? lim : 8));
        else if (lim > 0 && pick < 88)
            it.item_id = ITEM_ID_W'($urandom_range(1, lim));
        else if (pick < 94)
            it.item_id = pick[0] ? '0 : ITEM_ID_W'($urandom_range(lim + 1, 2047));
        else
            it.item_id = ITEM_ID_W'($urandom());
        return it;
    endfunction

    // Offers one item after a random gap and holds it until accepted.
    task automatic send_item(input mtfd_in_t it);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering items until every expected result has come back.
    // The first edge lets the monitor note an item accepted on the edge before.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer; a read is compared with the tracked item count.
    task automatic apb_cycle(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (wr && addr == ADDR_ITEM_COUNT)
            board.set_count(data);
        if (!wr && prdata[COUNT_W-1:0] !== board.item_count)
            board.flag($sformatf("item_count readback mismatch: expected %0d, got %0d",
                                 board.item_count, prdata[COUNT_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Changes the item count with the core idle and reads it back.
    task automatic set_item_count(input int value);
        drain();
        apb_cycle(1'b1, ADDR_ITEM_COUNT, APB_DATA_W'(value));
        apb_cycle(1'b0, ADDR_ITEM_COUNT, '0);
    endtask

    // Result side: random stalls, and one long hold when the sender asks for it.
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = $urandom_range(0, out_stall_max);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Main sequence: reset, directed items, then random phases with several counts.
    initial
    begin
        int phase_counts [8];
        int count;
        phase_counts = '{1024, 2, 1, 0, 2047, 37, 1024, 300};
        board         = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_gap_max    = 5;
        out_stall_max = 5;
        hold_request  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset order: top, bottom, repeat of the new top, and bad ids.
        send_item(lookup(1'b0, 1));
        send_item(lookup(1'b0, 1024));
        send_item(lookup(1'b0, 1024));
        send_item(lookup(1'b0, 1));
        send_item(lookup(1'b0, 0));
        send_item(lookup(1'b0, 1025));
        send_item(lookup(1'b0, 2047));

        // A restart still applies when the id is bad.
        send_item(lookup(1'b1, 0));
        send_item(lookup(1'b0, 1024));
        send_item(lookup(1'b1, 512));
        send_item(lookup(1'b0, 1023));

        // A write to an unused register leaves the count alone.
        drain();
        apb_cycle(1'b1, ADDR_SPARE, 32'h0000_0005);
        apb_cycle(1'b0, ADDR_ITEM_COUNT, '0);

        // Shrinking the count keeps the order; ids above the count are bad.
        set_item_count(4);
        send_item(lookup(1'b0, 3));
        send_item(lookup(1'b0, 700));
        send_item(lookup(1'b0, 5));
        send_item(lookup(1'b0, 4));

        set_item_count(1);
        send_item(lookup(1'b0, 1));
        send_item(lookup(1'b0, 2));
        send_item(lookup(1'b1, 1));

        // With a zero count every id is bad.
        set_item_count(0);
        send_item(lookup(1'b0, 1));
        send_item(lookup(1'b1, 1024));

        // A count above the stack size still rejects ids past the stack.
        set_item_count(2047);
        send_item(lookup(1'b0, 1024));
        send_item(lookup(1'b0, 1025));
        send_item(lookup(1'b0, 2047));

        // Random phases, each with its own count and idling pattern.
        for (int p = 0; p < 9; p++)
        begin
            count = (p < 8) ? phase_counts[p] : $urandom_range(1, 1024);
            set_item_count(count);
            in_gap_max    = (p % 3 == 1) ? 0 : 5;
            out_stall_max = (p % 3 == 2) ? 0 : 5;
            if (p == 1 || p == 6)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item());
                if (p == 5 && n == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
